// ----- rtl/core/sorted_insert_list_defines.svh -----
// assertion macros used by the sorted insert list checker
`ifndef SORTED_INSERT_LIST_DEFINES_SVH
`define SORTED_INSERT_LIST_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define SIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_insert_list assertion failed");

// next-cycle implication
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_insert_list assertion failed");

`endif

// ----- rtl/core/sil_pkg.sv -----
// types, codes and constants of the sorted insert list
package sil_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DUMP = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_DUMP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the offered value, clear the dump index
    logic compare;   // register the per-cell less-than flags
    logic insert;    // shift cells and emit the acknowledge
    logic dump;      // emit cell 0 and rotate the occupied cells
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dump_end;  // current dump result is the final one
  } stat_t;

endpackage

// ----- rtl/core/sil_ctrl.sv -----
// controller state machine of the sorted insert list
module sil_ctrl
  import sil_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  op_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = (op_e'(op_i) == OP_DUMP) ? S_DUMP : S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d = S_INS;
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        state_d = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.dump = 1'b1;
        if (stat_i.dump_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/sil_dp.sv -----
// datapath: chain of compare-and-shift cells, count and result registers
module sil_dp
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output stat_t                      stat_o,
  output logic                       res_valid_o,
  output logic                       kind_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [CNT_W-1:0]           position_o,
  output logic signed [DATA_W-1:0]   entry_value_o,
  output logic [CNT_W-1:0]           count_o,
  output logic                       last_o
);

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic signed [DATA_W-1:0] cell_d [CAPACITY];
  logic signed [DATA_W-1:0] v_q;
  logic [CAPACITY-1:0]      lt_q, lt_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         idx_q;
  logic [CNT_W-1:0]         pos_enc;
  logic [CNT_W-1:0]         top_idx;
  logic                     full;
  logic                     empty;
  logic                     dump_end;

  logic                     res_valid_q, res_valid_d;
  logic                     kind_q, kind_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic [CNT_W-1:0]         position_q, position_d;
  logic signed [DATA_W-1:0] entry_value_q, entry_value_d;
  logic [CNT_W-1:0]         count_out_q, count_out_d;
  logic                     last_q, last_d;

  assign full     = (count_q >= CapCnt);
  assign empty    = (count_q == '0);
  assign top_idx  = count_q - CNT_W'(1);
  assign dump_end = empty || (idx_q == top_idx);
  assign stat_o.dump_end = dump_end;

  // per-cell work: compare, insert shift, dump rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic take_new;
    logic signed [DATA_W-1:0] below;
    logic signed [DATA_W-1:0] above;

    assign lt_d[i] = (CNT_W'(i) < count_q) && (cell_q[i] < v_q);

    if (i == 0) begin : g_first
      assign take_new = 1'b1;
      assign below    = v_q;
    end else begin : g_rest
      assign take_new = lt_q[i-1];
      assign below    = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign above = cell_q[i];
    end else begin : g_mid
      assign above = cell_q[i+1];
    end

    always_comb begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert && !full && !lt_q[i]) begin
        cell_d[i] = take_new ? v_q : below;
      end else if (cmd_i.dump && !empty) begin
        // the top occupied cell takes the head so the list comes back whole
        cell_d[i] = (CNT_W'(i) == top_idx) ? cell_q[0] : above;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  // lt_q is a thermometer code; the insert position is its boundary
  always_comb begin
    logic left;
    logic right;
    pos_enc = '0;
    for (int unsigned i = 0; i <= CAPACITY; i++) begin
      left  = (i == 0) ? 1'b1 : lt_q[i-1];
      right = (i == CAPACITY) ? 1'b0 : lt_q[i];
      if (left && !right) begin
        pos_enc = pos_enc | CNT_W'(i);
      end
    end
  end

  always_comb begin
    count_d       = count_q;
    res_valid_d   = 1'b0;
    kind_d        = kind_q;
    status_d      = status_q;
    position_d    = position_q;
    entry_value_d = entry_value_q;
    count_out_d   = count_out_q;
    last_d        = last_q;
    if (cmd_i.insert) begin
      res_valid_d   = 1'b1;
      kind_d        = KIND_ACK;
      entry_value_d = v_q;
      last_d        = 1'b1;
      if (full) begin
        status_d    = ST_FULL;
        position_d  = '0;
        count_out_d = count_q;
      end else begin
        status_d    = ST_OK;
        position_d  = pos_enc;
        count_d     = count_q + CNT_W'(1);
        count_out_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.dump) begin
      res_valid_d = 1'b1;
      kind_d      = KIND_DUMP;
      last_d      = dump_end;
      if (empty) begin
        status_d      = ST_EMPTY;
        position_d    = '0;
        entry_value_d = '0;
        count_out_d   = '0;
      end else begin
        status_d      = ST_OK;
        position_d    = idx_q;
        entry_value_d = cell_q[0];
        count_out_d   = count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q   <= value_i;
      idx_q <= '0;
    end else if (cmd_i.dump) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    if (cmd_i.compare) begin
      lt_q <= lt_d;
    end
    kind_q        <= kind_d;
    status_q      <= status_d;
    position_q    <= position_d;
    entry_value_q <= entry_value_d;
    count_out_q   <= count_out_d;
    last_q        <= last_d;
  end

  assign res_valid_o   = res_valid_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_value_o = entry_value_q;
  assign count_o       = count_out_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/core/sorted_insert_list.sv -----
// top level of the sorted insert list: controller plus cell datapath
//
// Keeps up to CAPACITY signed 32-bit values in ascending order.
// Command channel: an item (op_i, value_i) is taken at a rising edge with
// start high and busy low. op_i = 0 inserts value_i before the first entry
// that is greater or equal; op_i = 1 dumps the list.
// Result channel: each result sits on the result ports for one cycle with
// res_valid_o high; the receiver cannot stall, so nothing is held back.
// Insert: the cell chain compares in state S_CMP and shifts in S_INS, so
// busy stays high through both states, the acknowledge is registered from
// S_INS, and no new item is taken until the controller is back in idle.
// Dump: one entry per cycle, taken from the head cell while the occupied
// cells rotate; no new item is taken until the dump ends, the first result
// is registered from the first S_DUMP cycle, and last_o marks the end.
// A full list drops the value and answers with status full.
// Reset empties the list and clears the controller and res_valid_o.
module sorted_insert_list
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     res_valid_o,
  output logic                     kind_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [CNT_W-1:0]         position_o,
  output logic signed [DATA_W-1:0] entry_value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     last_o
);

  cmd_t  cmd;
  stat_t stat;

  sil_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (value_i),
    .stat_o        (stat),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_value_o (entry_value_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/core/sil_checker.sv -----
// port-level checker of the sorted insert list and its bind
`include "sorted_insert_list_defines.svh"

module sil_checker
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     res_valid_o,
  input logic                     kind_o,
  input logic [STATUS_W-1:0]      status_o,
  input logic [CNT_W-1:0]         position_o,
  input logic [CNT_W-1:0]         count_o,
  input logic                     last_o
);

  // an accepted item keeps the block busy in the following cycle
  `SIL_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // a dump stream has no gaps until its last entry
  `SIL_ASSERT_NEXT(a_dump_stream, clk_i, rst_ni, res_valid_o && !last_o, res_valid_o)

  // a stored value lands inside the new count, which never exceeds capacity
  `SIL_ASSERT_IMPL(a_ack_pos, clk_i, rst_ni, res_valid_o && status_o == ST_OK,
    position_o < count_o && count_o <= CNT_W'(CAPACITY))

  // the empty answer is a lone final result with zero count
  `SIL_ASSERT_IMPL(a_empty_last, clk_i, rst_ni, res_valid_o && status_o == ST_EMPTY,
    last_o && count_o == '0 && kind_o == KIND_DUMP)

endmodule

bind sorted_insert_list sil_checker #(.CAPACITY(CAPACITY)) u_sil_checker (.*);
